// File: hw/rtl/chgs_pkg.sv
// Shared types and constants for the convex hull block.
`default_nettype none
package chgs_pkg;

    // Tag that the front end attaches to every queued point.
    typedef struct packed {
        logic final_pt;
        logic keep;
    } t_ctrl;

    localparam int CTRL_BITS   = $bits(t_ctrl);
    localparam int QUEUE_DEPTH = 4;

endpackage
`default_nettype wire

// File: hw/rtl/chgs_pt_if.sv
// Point input channel: valid/ready handshake with point payload.
`default_nettype none
interface chgs_pt_if #(
    parameter int COORD_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic                         final_point;

    modport source (output valid, px, py, final_point, input ready);
    modport sink   (input valid, px, py, final_point, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/chgs_hull_if.sv
// Hull vertex output channel: valid/ready handshake with vertex payload.
`default_nettype none
interface chgs_hull_if #(
    parameter int COORD_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] hull_x;
    logic signed [COORD_BITS-1:0] hull_y;
    logic                         last_vertex;
    logic                         dropped;

    modport source (output valid, hull_x, hull_y, last_vertex, dropped, input ready);
    modport sink   (input valid, hull_x, hull_y, last_vertex, dropped, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/chgs_queue.sv
// Short FIFO between the front end and the hull engine.
`default_nettype none
module chgs_queue #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/chgs_front.sv
// Front end: accepts points, tags each as kept or dropped, queues it.
`default_nettype none
module chgs_front #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    chgs_pt_if.sink                                        i_pt,
    input  wire logic                                      i_full,
    output logic                                           o_push,
    output logic [2*COORD_BITS+chgs_pkg::CTRL_BITS-1:0]    o_entry
);
    import chgs_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [CW-1:0] r_cnt;
    t_ctrl         ctrl;

    assign i_pt.ready = !i_full;
    assign o_push     = i_pt.valid && !i_full;
    assign ctrl.final_pt = i_pt.final_point;
    assign ctrl.keep     = (r_cnt < CW'(MAX_POINTS));
    assign o_entry    = {ctrl, i_pt.py, i_pt.px};

    // Mirror the engine's fill count so the keep tag is known at entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_push) begin
            if (i_pt.final_point) begin
                r_cnt <= '0;
            end else if (ctrl.keep) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/chgs_back.sv
// Hull engine: stores points, finds pivot, sorts by angle, scans, emits.
`default_nettype none
module chgs_back #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_q_valid,
    input  wire logic [2*COORD_BITS+chgs_pkg::CTRL_BITS-1:0] i_q_data,
    output logic                                           o_q_pop,
    chgs_hull_if.source                                    o_hull
);
    import chgs_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int PW  = 2 * CB;
    localparam int DW  = CB + 1;
    localparam int MW  = 2 * DW;
    localparam int IW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);

    typedef enum logic [4:0] {
        S_LOAD, S_PIV_RD, S_PIV_CMP, S_SW_RD, S_SW_W1, S_SW_W2,
        S_SRT_KEY, S_SRT_KEYW, S_SRT_RD, S_SRT_MUL, S_SRT_DEC,
        S_SC_INIT, S_SC_P1, S_SC_RDI, S_SC_TST, S_SC_MUL, S_SC_DEC, S_SC_POP,
        S_EM_RD, S_EM_OUT
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt, r_n, n_n, r_i, n_i, r_j, n_j, r_top, n_top;
    logic [IW-1:0] r_best, n_best;
    logic          r_ovf, n_ovf;
    logic [PW-1:0] r_pv, n_pv, r_key, n_key, r_t1, n_t1, r_t2, n_t2;
    logic          r_ov, n_ov, r_last, n_last, r_drop, n_drop;
    logic [PW-1:0] r_hv, n_hv;
    logic signed [MW-1:0] r_p1, r_p2;

    // Point store and hull stack memories.
    logic [PW-1:0] r_pts [MAX_POINTS];
    logic [PW-1:0] r_stk [MAX_POINTS];
    logic [PW-1:0] r_prd, r_srd;
    logic          p_we, p_re, s_we, s_re;
    logic [IW-1:0] p_wa, p_ra, s_wa, s_ra;
    logic [PW-1:0] p_wd, s_wd;

    t_ctrl         q_ctrl;
    logic [PW-1:0] q_pt;
    logic signed [CB-1:0] m_ox, m_oy, m_ax, m_ay, m_bx, m_by;
    logic signed [DW-1:0] d_ax, d_ay, d_bx, d_by;
    logic signed [CB-1:0] kx, ky, cx, cy, bvx, bvy;
    logic signed [DW-1:0] sa, sb;
    logic          key_first, out_free;
    logic [PW-1:0] mo, ma;

    assign q_ctrl = t_ctrl'(i_q_data[PW +: CTRL_BITS]);
    assign q_pt   = i_q_data[PW-1:0];
    assign o_q_pop = (r_state == S_LOAD) && i_q_valid;
    assign out_free = !r_ov || o_hull.ready;

    assign o_hull.valid       = r_ov;
    assign o_hull.hull_x      = r_hv[CB-1:0];
    assign o_hull.hull_y      = r_hv[PW-1:CB];
    assign o_hull.last_vertex = r_last;
    assign o_hull.dropped     = r_drop;

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            r_pts[p_wa] <= p_wd;
        end
        if (p_re) begin
            r_prd <= r_pts[p_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_stk[s_wa] <= s_wd;
        end
        if (s_re) begin
            r_srd <= r_stk[s_ra];
        end
    end

    // Shared cross product unit: origin and a chosen by state, b is the point just read.
    always_comb begin
        mo = (r_state == S_SC_MUL) ? r_t2 : r_pv;
        ma = (r_state == S_SC_MUL) ? r_t1 : r_key;
        m_ox = mo[CB-1:0];  m_oy = mo[PW-1:CB];
        m_ax = ma[CB-1:0];  m_ay = ma[PW-1:CB];
        m_bx = r_prd[CB-1:0]; m_by = r_prd[PW-1:CB];
        d_ax = DW'(m_ax) - DW'(m_ox);
        d_ay = DW'(m_ay) - DW'(m_oy);
        d_bx = DW'(m_bx) - DW'(m_ox);
        d_by = DW'(m_by) - DW'(m_oy);
    end

    always_ff @(posedge i_clk) begin
        r_p1 <= MW'(d_ax) * MW'(d_by);
        r_p2 <= MW'(d_ay) * MW'(d_bx);
    end

    // Angular order of the held key against the point just read.
    always_comb begin
        kx = r_key[CB-1:0]; ky = r_key[PW-1:CB];
        cx = r_prd[CB-1:0]; cy = r_prd[PW-1:CB];
        sa = DW'(kx) + DW'(ky);
        sb = DW'(cx) + DW'(cy);
        if (r_prd == r_pv)       key_first = 1'b0;
        else if (r_key == r_pv)  key_first = 1'b1;
        else if (r_p1 > r_p2)    key_first = 1'b1;
        else if (r_p1 < r_p2)    key_first = 1'b0;
        else if (sa != sb)       key_first = (sa < sb);
        else if (ky != cy)       key_first = (ky < cy);
        else                     key_first = (kx < cx);
    end

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_n = r_n; n_i = r_i; n_j = r_j;
        n_top = r_top; n_best = r_best; n_ovf = r_ovf; n_pv = r_pv;
        n_key = r_key; n_t1 = r_t1; n_t2 = r_t2; n_ov = r_ov;
        n_last = r_last; n_drop = r_drop; n_hv = r_hv;
        p_we = 1'b0; p_wa = '0; p_wd = r_prd; p_re = 1'b0; p_ra = '0;
        s_we = 1'b0; s_wa = '0; s_wd = r_prd; s_re = 1'b0; s_ra = '0;
        bvx = r_prd[CB-1:0]; bvy = r_prd[PW-1:CB];
        if (r_ov && o_hull.ready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            S_LOAD: begin
                if (i_q_valid) begin
                    if (q_ctrl.keep) begin
                        p_we  = 1'b1;
                        p_wa  = r_cnt[IW-1:0];
                        p_wd  = q_pt;
                        n_cnt = r_cnt + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (q_ctrl.final_pt) begin
                        n_n     = r_cnt + CW'(q_ctrl.keep);
                        n_i     = '0;
                        n_state = S_PIV_RD;
                    end
                end
            end
            S_PIV_RD: begin
                p_re = 1'b1; p_ra = r_i[IW-1:0];
                n_state = S_PIV_CMP;
            end
            S_PIV_CMP: begin
                if (r_i == '0 || bvy < $signed(r_pv[PW-1:CB]) ||
                    (bvy == $signed(r_pv[PW-1:CB]) && bvx < $signed(r_pv[CB-1:0]))) begin
                    n_pv   = r_prd;
                    n_best = r_i[IW-1:0];
                end
                n_i = r_i + CW'(1);
                n_state = (r_i + CW'(1) < r_n) ? S_PIV_RD : S_SW_RD;
            end
            S_SW_RD: begin
                p_re = 1'b1; p_ra = '0;
                n_state = S_SW_W1;
            end
            S_SW_W1: begin
                p_we = 1'b1; p_wa = r_best; p_wd = r_prd;
                n_state = S_SW_W2;
            end
            S_SW_W2: begin
                p_we = 1'b1; p_wa = '0; p_wd = r_pv;
                n_i = CW'(2);
                n_state = S_SRT_KEY;
            end
            S_SRT_KEY: begin
                if (r_i < r_n) begin
                    p_re = 1'b1; p_ra = r_i[IW-1:0];
                    n_j = r_i;
                    n_state = S_SRT_KEYW;
                end else begin
                    n_state = S_SC_INIT;
                end
            end
            S_SRT_KEYW: begin
                n_key = r_prd;
                n_state = S_SRT_RD;
            end
            S_SRT_RD: begin
                if (r_j > CW'(1)) begin
                    p_re = 1'b1; p_ra = IW'(r_j - CW'(1));
                    n_state = S_SRT_MUL;
                end else begin
                    p_we = 1'b1; p_wa = r_j[IW-1:0]; p_wd = r_key;
                    n_i = r_i + CW'(1);
                    n_state = S_SRT_KEY;
                end
            end
            S_SRT_MUL: begin
                n_state = S_SRT_DEC;
            end
            S_SRT_DEC: begin
                p_we = 1'b1; p_wa = r_j[IW-1:0];
                if (key_first) begin
                    // Shift the neighbor up and keep walking down.
                    p_wd = r_prd;
                    n_j = r_j - CW'(1);
                    n_state = S_SRT_RD;
                end else begin
                    p_wd = r_key;
                    n_i = r_i + CW'(1);
                    n_state = S_SRT_KEY;
                end
            end
            S_SC_INIT: begin
                s_we = 1'b1; s_wa = '0; s_wd = r_pv;
                n_t1 = r_pv; n_top = CW'(1);
                if (r_n >= CW'(2)) begin
                    p_re = 1'b1; p_ra = IW'(1);
                    n_state = S_SC_P1;
                end else begin
                    n_state = S_EM_RD;
                end
            end
            S_SC_P1: begin
                s_we = 1'b1; s_wa = IW'(1); s_wd = r_prd;
                n_t2 = r_t1; n_t1 = r_prd; n_top = CW'(2);
                n_i = CW'(2);
                n_state = S_SC_RDI;
            end
            S_SC_RDI: begin
                if (r_i < r_n) begin
                    p_re = 1'b1; p_ra = r_i[IW-1:0];
                    n_state = S_SC_TST;
                end else begin
                    n_state = S_EM_RD;
                end
            end
            S_SC_TST: begin
                if (r_top >= CW'(2)) begin
                    n_state = S_SC_MUL;
                end else begin
                    s_we = 1'b1; s_wa = r_top[IW-1:0]; s_wd = r_prd;
                    n_t2 = r_t1; n_t1 = r_prd; n_top = r_top + CW'(1);
                    n_i = r_i + CW'(1);
                    n_state = S_SC_RDI;
                end
            end
            S_SC_MUL: begin
                n_state = S_SC_DEC;
            end
            S_SC_DEC: begin
                if (!(r_p1 > r_p2)) begin
                    // Not a strict left turn: drop the top entry.
                    n_top = r_top - CW'(1);
                    n_t1 = r_t2;
                    if (r_top >= CW'(3)) begin
                        s_re = 1'b1; s_ra = IW'(r_top - CW'(3));
                        n_state = S_SC_POP;
                    end else begin
                        n_state = S_SC_TST;
                    end
                end else begin
                    s_we = 1'b1; s_wa = r_top[IW-1:0]; s_wd = r_prd;
                    n_t2 = r_t1; n_t1 = r_prd; n_top = r_top + CW'(1);
                    n_i = r_i + CW'(1);
                    n_state = S_SC_RDI;
                end
            end
            S_SC_POP: begin
                n_t2 = r_srd;
                n_state = S_SC_TST;
            end
            S_EM_RD: begin
                s_re = 1'b1; s_ra = IW'(r_top - CW'(1));
                n_top = r_top - CW'(1);
                n_state = S_EM_OUT;
            end
            S_EM_OUT: begin
                if (out_free) begin
                    n_ov = 1'b1; n_hv = r_srd;
                    n_last = (r_top == '0); n_drop = r_ovf;
                    if (r_top == '0) begin
                        n_cnt = '0; n_ovf = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_EM_RD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_ov    <= 1'b0;
            r_top   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_ov    <= n_ov;
            r_top   <= n_top;
        end
        r_n <= n_n; r_i <= n_i; r_j <= n_j; r_best <= n_best; r_pv <= n_pv;
        r_key <= n_key; r_t1 <= n_t1; r_t2 <= n_t2; r_last <= n_last;
        r_drop <= n_drop; r_hv <= n_hv;
    end

    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= CW'(MAX_POINTS))
        else $error("hull stack overrun");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_POINTS))
        else $error("point store overrun");
    a_sort_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRT_RD) |-> (r_j <= r_i && r_i < r_n && r_j >= CW'(1)))
        else $error("sort index out of range");
    a_load_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == S_LOAD))
        else $error("queue popped while busy");
endmodule
`default_nettype wire

// File: hw/rtl/convex_hull_graham_scan.sv
// Top level of the Graham scan convex hull block.
// Usage:
//   Points enter on i_pt (valid/ready); one transaction is one point, and the
//   transaction with final_point set closes the set and starts the hull.
//   Hull vertices leave on o_hull, last hull point first, pivot last with
//   last_vertex set; dropped is set on every vertex of a set that overflowed.
// Loading and processing:
//   Loading takes one point per cycle; a four-entry queue parts the front end
//   from the engine, so points are taken until the queue fills while the
//   engine is busy. After the final point the engine searches all points for
//   the pivot, swaps it into slot zero, insertion-sorts the rest by angle
//   (comparisons of order n*n worst case), runs the stack tests of the scan
//   and emits the hull vertices. One point memory read per step sets the pace.
// Reset:
//   i_rst_n is synchronous, active low; it empties the queue and clears the
//   fill count, so the next transaction starts a new set.
// Back pressure:
//   A stalled o_hull holds the vertex register and the engine waits; input
//   keeps filling the queue and stalls i_pt when it is full.
`default_nettype none
module convex_hull_graham_scan #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    chgs_pt_if.sink     i_pt,
    chgs_hull_if.source o_hull
);
    import chgs_pkg::*;

    localparam int EW = 2 * COORD_BITS + CTRL_BITS;

    logic          push, full, q_valid, q_pop;
    logic [EW-1:0] entry, q_data;

    // Front end: accept and tag points.
    chgs_front #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (i_pt),
        .i_full  (full),
        .o_push  (push),
        .o_entry (entry)
    );

    // Decoupling queue.
    chgs_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (entry),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // Engine: store, sort, scan, emit.
    chgs_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_hull    (o_hull)
    );
endmodule
`default_nettype wire

// File: tb/sv/hull_checker.sv
// Checker that predicts and compares hull vertices for the convex hull block.
`timescale 1ns / 100ps
`default_nettype none
module hull_checker #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    chgs_pt_if        pt,
    chgs_hull_if      hull,
    output int        o_errors,
    output int        o_pending,
    output int        o_vertices,
    output int        o_sets
);
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         last;
        logic                         drop;
    } t_vertex;

    longint  set_x [MAX_POINTS];
    longint  set_y [MAX_POINTS];
    int      set_count;
    bit      set_overflow;
    t_vertex hull_queue[$];

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_vertices = 0;
        o_sets = 0;
        set_count = 0;
        set_overflow = 0;
    end

    function automatic longint turn_of(int o, int a, int b);
        return (set_x[a] - set_x[o]) * (set_y[b] - set_y[o])
             - (set_y[a] - set_y[o]) * (set_x[b] - set_x[o]);
    endfunction

    function automatic bit on_pivot(int a);
        return set_x[a] == set_x[0] && set_y[a] == set_y[0];
    endfunction

    function automatic bit angle_less(int a, int b);
        longint cr;
        if (on_pivot(b)) return 0;
        if (on_pivot(a)) return 1;
        cr = turn_of(0, a, b);
        if (cr != 0) return cr > 0;
        if (set_x[a] + set_y[a] != set_x[b] + set_y[b])
            return set_x[a] + set_y[a] < set_x[b] + set_y[b];
        if (set_y[a] != set_y[b]) return set_y[a] < set_y[b];
        return set_x[a] < set_x[b];
    endfunction

    function automatic void swap_pts(int i, int j);
        longint t;
        t = set_x[i]; set_x[i] = set_x[j]; set_x[j] = t;
        t = set_y[i]; set_y[i] = set_y[j]; set_y[j] = t;
    endfunction

    // Run the scan on the collected set and queue its vertices in pop order.
    function automatic void predict_hull();
        int      stack[MAX_POINTS];
        int      top;
        int      low;
        t_vertex v;
        top = 0;
        low = 0;
        for (int i = 1; i < set_count; i++)
            if (set_y[i] < set_y[low] || (set_y[i] == set_y[low] && set_x[i] < set_x[low]))
                low = i;
        swap_pts(0, low);
        for (int i = 2; i < set_count; i++)
            for (int j = i; j > 1 && angle_less(j, j - 1); j--)
                swap_pts(j, j - 1);
        stack[top++] = 0;
        if (set_count >= 2) stack[top++] = 1;
        for (int i = 2; i < set_count; i++) begin
            while (top >= 2 && turn_of(stack[top-2], stack[top-1], i) <= 0) top--;
            stack[top++] = i;
        end
        while (top > 0) begin
            top--;
            v.x = COORD_BITS'(set_x[stack[top]]);
            v.y = COORD_BITS'(set_y[stack[top]]);
            v.last = (top == 0);
            v.drop = set_overflow;
            hull_queue = {hull_queue, v};
        end
    endfunction

    task automatic report(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_vertex want;
        if (i_rst_n && pt.valid && pt.ready) begin
            if (set_count < MAX_POINTS) begin
                set_x[set_count] = pt.px;
                set_y[set_count] = pt.py;
                set_count++;
            end else begin
                set_overflow = 1;
            end
            if (pt.final_point) begin
                predict_hull();
                set_count = 0;
                set_overflow = 0;
                o_sets++;
            end
        end
        if (i_rst_n && hull.valid && hull.ready) begin
            o_vertices++;
            if (hull_queue.size() == 0) begin
                report($sformatf("unexpected vertex (%0d,%0d)", hull.hull_x, hull.hull_y));
            end else begin
                want = hull_queue.pop_front();
                if (hull.hull_x !== want.x || hull.hull_y !== want.y)
                    report($sformatf("vertex (%0d,%0d) want (%0d,%0d)",
                                     hull.hull_x, hull.hull_y, want.x, want.y));
                if (hull.last_vertex !== want.last)
                    report($sformatf("last_vertex %b want %b", hull.last_vertex, want.last));
                if (hull.dropped !== want.drop)
                    report($sformatf("dropped %b want %b", hull.dropped, want.drop));
            end
        end
        o_pending = hull_queue.size();
    end
endmodule
`default_nettype wire

// File: tb/sv/convex_hull_graham_scan_test.sv
// Stimulus and verdict for the convex hull block test.
`timescale 1ns / 100ps
`default_nettype none
module convex_hull_graham_scan_test;
    localparam int MAX_PTS  = 64;
    localparam int CB       = 16;
    localparam int LIMIT    = 1500000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   errors, pending, vertices, sets;
    int   cycles = 0;
    int   send_idle = 0;   // percent of cycles the sender idles
    int   recv_idle = 0;   // percent of cycles the receiver stalls
    int   hold_off = 0;    // remaining cycles of a long receiver stall
    int   sent = 0;

    chgs_pt_if   #(.COORD_BITS(CB)) pt_ch ();
    chgs_hull_if #(.COORD_BITS(CB)) hull_ch ();

    convex_hull_graham_scan #(.MAX_POINTS(MAX_PTS), .COORD_BITS(CB)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pt   (pt_ch.sink),
        .o_hull (hull_ch.source)
    );

    hull_checker #(.MAX_POINTS(MAX_PTS), .COORD_BITS(CB)) checker_inst (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .pt        (pt_ch),
        .hull      (hull_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_vertices(vertices),
        .o_sets    (sets)
    );

    always #5 i_clk = ~i_clk;

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Drive ready at the falling edge; a long hold-off overrides the random stall.
    initial hull_ch.ready = 0;
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            hull_ch.ready <= 0;
        end else begin
            hull_ch.ready <= (int'($urandom_range(99)) >= recv_idle);
        end
    end

    initial begin
        pt_ch.valid = 0;
        pt_ch.px = 0;
        pt_ch.py = 0;
        pt_ch.final_point = 0;
    end

    // Offer one point and hold it until the transaction completes; valid stays
    // high into the next call so points can follow back to back.
    task automatic send_point(logic signed [CB-1:0] x, logic signed [CB-1:0] y, bit fin);
        while (int'($urandom_range(99)) < send_idle) begin
            pt_ch.valid <= 0;
            @(negedge i_clk);
        end
        pt_ch.valid <= 1;
        pt_ch.px <= x;
        pt_ch.py <= y;
        pt_ch.final_point <= fin;
        do @(posedge i_clk); while (!pt_ch.ready);
        sent++;
        @(negedge i_clk);
    endtask

    // Random set: mostly small, sometimes large or overflowing; narrow, +-100 or full range.
    task automatic random_set();
        int n;
        int span;
        logic signed [CB-1:0] x, y;
        n = ($urandom_range(9) == 0) ? int'($urandom_range(70, 60))
                                     : int'($urandom_range(8, 1));
        span = int'($urandom_range(3));
        for (int i = 0; i < n; i++) begin
            case (span)
                0: begin
                    x = CB'($urandom_range(7));
                    y = CB'($urandom_range(7));
                end
                1: begin
                    x = CB'(int'($urandom_range(200)) - 100);
                    y = CB'(int'($urandom_range(200)) - 100);
                end
                default: begin
                    x = CB'($urandom);
                    y = CB'($urandom);
                end
            endcase
            send_point(x, y, i == n - 1);
        end
    endtask

    task automatic drain();
        pt_ch.valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // Single point at the extremes, then two points.
        send_point(16'sh7fff, 16'sh8000, 1);
        send_point(16'sh8000, 16'sh7fff, 0);
        send_point(16'sh7fff, 16'sh8000, 1);
        // Square with a pivot copy, a collinear point and interior points.
        send_point(0, 0, 0);
        send_point(4, 0, 0);
        send_point(0, 0, 0);
        send_point(2, 0, 0);
        send_point(4, 4, 0);
        send_point(2, 2, 0);
        send_point(0, 4, 0);
        send_point(1, 3, 0);
        send_point(3, 1, 1);
        // Full-range triangle.
        send_point(16'sh8000, 16'sh8000, 0);
        send_point(16'sh7fff, 16'sh8000, 0);
        send_point(16'sh0000, 16'sh7fff, 1);
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle = 0;  recv_idle = 0;  end
                1: begin send_idle = 75; recv_idle = 0;  end
                2: begin send_idle = 0;  recv_idle = 75; end
                default: begin send_idle = 31; recv_idle = 31; end
            endcase
            if (ph == 0) hold_off = 400;  // let the input queue fill and stall
            while (sent < 15 + (ph + 1) * 50) random_set();
            drain();
        end
        $display("sent %0d points in %0d sets, checked %0d hull vertices",
                 sent, sets, vertices);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
